>>> src/efcu_pkg.sv
package efcu_pkg;

    // Default parameter values
    localparam int POS_WIDTH_DEF  = 32;
    localparam int VEC_FRAC_DEF   = 14;
    localparam int TRIG_STEPS_DEF = 16;

    // Register indexes
    localparam logic [2:0] REG_MOVE_SPEED  = 3'd0;
    localparam logic [2:0] REG_LOOK_SENS   = 3'd1;
    localparam logic [2:0] REG_START_X     = 3'd2;
    localparam logic [2:0] REG_START_Y     = 3'd3;
    localparam logic [2:0] REG_START_Z     = 3'd4;
    localparam logic [2:0] REG_START_YAW   = 3'd5;
    localparam logic [2:0] REG_START_PITCH = 3'd6;

    localparam logic [23:0] MOVE_SPEED_RST = 24'd163840;
    localparam logic [15:0] LOOK_SENS_RST  = 16'd3277;

    // Modes and directions
    localparam logic [1:0] MODE_MOVE    = 2'd0;
    localparam logic [1:0] MODE_ROTATE  = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    localparam logic [2:0] DIR_FWD   = 3'd0;
    localparam logic [2:0] DIR_BACK  = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_RIGHT = 3'd3;
    localparam logic [2:0] DIR_UP    = 3'd4;
    localparam logic [2:0] DIR_DOWN  = 3'd5;

    // Angle constants, degrees Q16.16
    localparam logic signed [25:0] DEG_90      = 26'sd5898240;
    localparam logic signed [25:0] DEG_180     = 26'sd11796480;
    localparam logic        [34:0] DEG_180_U   = 35'd11796480;
    localparam logic        [34:0] DEG_360_U   = 35'd23592960;
    localparam logic        [34:0] YAW_OFFSET  = 35'd3031695360;
    localparam logic signed [33:0] PITCH_LIM   = 34'sd5832704;

    // Q2.30 constants
    localparam logic signed [33:0] GAIN_K   = 34'sd652032874;
    localparam logic signed [33:0] Q30_ONE  = 34'sd1073741824;

    // Serial multiplier widths
    localparam int MUL_A_W = 41;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic        [1:0]  mode;
        logic        [2:0]  direction;
        logic        [15:0] time_step;
        logic signed [15:0] mouse_dx;
        logic signed [15:0] mouse_dy;
    } efcu_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] front_x;
        logic signed [15:0] front_y;
        logic signed [15:0] front_z;
        logic signed [15:0] right_x;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
    } efcu_out_t;

    // Arctangent of 2^-i in degrees, Q16.16
    function automatic logic [21:0] atan_deg(input logic [4:0] i);
        logic [21:0] r;
        case (i)
            5'd0:    r = 22'd2949120;
            5'd1:    r = 22'd1740967;
            5'd2:    r = 22'd919879;
            5'd3:    r = 22'd466945;
            5'd4:    r = 22'd234379;
            5'd5:    r = 22'd117304;
            5'd6:    r = 22'd58666;
            5'd7:    r = 22'd29335;
            5'd8:    r = 22'd14668;
            5'd9:    r = 22'd7334;
            5'd10:   r = 22'd3667;
            5'd11:   r = 22'd1833;
            5'd12:   r = 22'd917;
            5'd13:   r = 22'd458;
            5'd14:   r = 22'd229;
            5'd15:   r = 22'd115;
            5'd16:   r = 22'd57;
            5'd17:   r = 22'd29;
            5'd18:   r = 22'd14;
            5'd19:   r = 22'd7;
            5'd20:   r = 22'd4;
            5'd21:   r = 22'd2;
            5'd22:   r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

>>> src/efcu_in_if.sv
interface efcu_in_if;
    logic               valid;
    logic               ready;
    efcu_pkg::efcu_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/efcu_out_if.sv
interface efcu_out_if;
    logic                valid;
    logic                ready;
    efcu_pkg::efcu_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/efcu_smul.sv
// Bit-serial signed multiplier: one multiplier bit per cycle, LSB first.
module efcu_smul (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [efcu_pkg::MUL_A_W-1:0]   a,
    input  logic signed [efcu_pkg::MUL_B_W-1:0]   b,
    output logic                                  done,
    output logic signed [efcu_pkg::MUL_P_W-1:0]   p
);
    localparam int PW = efcu_pkg::MUL_P_W;
    localparam int BW = efcu_pkg::MUL_B_W;
    localparam int CW = $clog2(BW);

    logic signed [PW-1:0] acc_reg, acc_next;
    logic signed [PW-1:0] a_reg, a_next;
    logic signed [BW-1:0] b_reg, b_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 last;

    assign last = (cnt_reg == CW'(BW - 1));

    // Add or, on the sign bit, subtract the shifted multiplicand
    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            a_next    = PW'(a);
            b_next    = b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = last ? (acc_reg - a_reg) : (acc_reg + a_reg);
            end
            a_next   = a_reg <<< 1;
            b_next   = b_reg >>> 1;
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

>>> src/efcu_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
module efcu_cordic #(
    parameter int STEPS = efcu_pkg::TRIG_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [24:0] angle,
    output logic               done,
    output logic signed [31:0] cos_out,
    output logic signed [31:0] sin_out
);
    localparam int IW = $clog2(STEPS + 1);

    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [25:0] z_reg, z_next;
    logic               neg_reg, neg_next;
    logic [IW-1:0]      i_reg, i_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic signed [31:0] c_reg, c_next;
    logic signed [31:0] s_reg, s_next;
    logic signed [25:0] ang_w;
    logic signed [33:0] dx, dy, xn, yn, xc, yc;
    logic signed [25:0] at;
    logic               last;

    assign ang_w = 26'(angle);
    assign dx    = y_reg >>> i_reg;
    assign dy    = x_reg >>> i_reg;
    assign at    = $signed({4'd0, efcu_pkg::atan_deg(5'(i_reg))});
    assign last  = (i_reg == IW'(STEPS - 1));
    assign xn    = (z_reg >= 0) ? (x_reg - dx) : (x_reg + dx);
    assign yn    = (z_reg >= 0) ? (y_reg + dy) : (y_reg - dy);

    // Clamp the final pair to +-1.0
    always_comb
    begin
        xc = xn;
        yc = yn;
        if (xn > efcu_pkg::Q30_ONE)  xc = efcu_pkg::Q30_ONE;
        if (xn < -efcu_pkg::Q30_ONE) xc = -efcu_pkg::Q30_ONE;
        if (yn > efcu_pkg::Q30_ONE)  yc = efcu_pkg::Q30_ONE;
        if (yn < -efcu_pkg::Q30_ONE) yc = -efcu_pkg::Q30_ONE;
    end

    // Fold into +-90 degrees, then rotate
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        neg_next  = neg_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        c_next    = c_reg;
        s_next    = s_reg;
        if (start)
        begin
            x_next    = efcu_pkg::GAIN_K;
            y_next    = '0;
            i_next    = '0;
            busy_next = 1'b1;
            if (ang_w > efcu_pkg::DEG_90)
            begin
                z_next   = ang_w - efcu_pkg::DEG_180;
                neg_next = 1'b1;
            end
            else if (ang_w < -efcu_pkg::DEG_90)
            begin
                z_next   = ang_w + efcu_pkg::DEG_180;
                neg_next = 1'b1;
            end
            else
            begin
                z_next   = ang_w;
                neg_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            x_next = xn;
            y_next = yn;
            z_next = (z_reg >= 0) ? (z_reg - at) : (z_reg + at);
            i_next = i_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                c_next    = 32'(neg_reg ? -xc : xc);
                s_next    = 32'(neg_reg ? -yc : yc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        neg_reg <= neg_next;
        c_reg   <= c_next;
        s_reg   <= s_next;
    end

    assign done    = done_reg;
    assign cos_out = c_reg;
    assign sin_out = s_reg;

endmodule

>>> src/euler_fly_camera_update.sv
// Channel    Dir   Payload                                  Transfer
// in_ch      in    mode, direction, time_step, mouse deltas valid & ready
// out_ch     out   position, front, right, up               valid & ready
// cfg        in    cfg_index, cfg_data                      cfg_we
//
// One item at a time. Products use a bit-serial multiplier. A move takes the speed
// product and one per axis; a rotate the look products, yaw wrap, CORDIC on yaw and
// pitch and the vector products; a restart the wrap, CORDIC and vector products.
// Reset gives the default pose and register values; no clearing pass.
// A finished pose sits in the output register while the next item is taken;
// the sequencer stalls at its end only while that register is still full.
module euler_fly_camera_update #(
    parameter int POS_WIDTH     = efcu_pkg::POS_WIDTH_DEF,
    parameter int VEC_FRAC_BITS = efcu_pkg::VEC_FRAC_DEF,
    parameter int TRIG_STEPS    = efcu_pkg::TRIG_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    efcu_in_if.sink     in_ch,
    efcu_out_if.source  out_ch
);
    localparam int PW  = POS_WIDTH;
    localparam int VW  = VEC_FRAC_BITS + 2;
    localparam int SH  = 30 - VEC_FRAC_BITS;
    localparam int MSH = VEC_FRAC_BITS + 16;
    localparam int AW  = efcu_pkg::MUL_A_W;
    localparam int BW  = efcu_pkg::MUL_B_W;
    localparam int PRW = efcu_pkg::MUL_P_W;

    localparam logic signed [63:0] POS_HI = (64'sd1 <<< (PW - 1)) - 64'sd1;
    localparam logic signed [63:0] POS_LO = -POS_HI - 64'sd1;
    localparam logic signed [VW-1:0] VONE = {2'b01, {VEC_FRAC_BITS{1'b0}}};
    localparam logic signed [33:0] VLIM = 34'sd1 <<< VEC_FRAC_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_VEL   = 4'd1;
    localparam logic [3:0] S_MOVE  = 4'd2;
    localparam logic [3:0] S_YMUL  = 4'd3;
    localparam logic [3:0] S_WRAP  = 4'd4;
    localparam logic [3:0] S_PMUL  = 4'd5;
    localparam logic [3:0] S_CORDY = 4'd6;
    localparam logic [3:0] S_CORDP = 4'd7;
    localparam logic [3:0] S_VMUL  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    function automatic logic signed [PW-1:0] sat_pos(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > POS_HI) r = POS_HI;
        if (v < POS_LO) r = POS_LO;
        return PW'(r);
    endfunction

    function automatic logic signed [VW-1:0] to_vec(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = (v + (34'sd1 <<< (SH - 1))) >>> SH;
        if (t > VLIM)  t = VLIM;
        if (t < -VLIM) t = -VLIM;
        return VW'(t);
    endfunction

    function automatic logic signed [33:0] mul30(input logic signed [PRW-1:0] p);
        return 34'((p + (PRW'(1) <<< 29)) >>> 30);
    endfunction

    function automatic logic signed [23:0] clamp_pitch(input logic signed [33:0] v);
        logic signed [33:0] r;
        r = v;
        if (v > efcu_pkg::PITCH_LIM)  r = efcu_pkg::PITCH_LIM;
        if (v < -efcu_pkg::PITCH_LIM) r = -efcu_pkg::PITCH_LIM;
        return 24'(r);
    endfunction

    // Configuration registers
    logic [23:0]        speed_reg;
    logic [15:0]        sens_reg;
    logic [31:0]        sx_reg, sy0_reg, sz_reg;
    logic [24:0]        syaw_reg;
    logic [23:0]        spitch_reg;

    // Pose state
    logic signed [PW-1:0] pos_reg [3];
    logic signed [PW-1:0] pos_next [3];
    logic signed [24:0]   yaw_reg, yaw_next;
    logic signed [23:0]   pitch_reg, pitch_next;
    logic signed [VW-1:0] front_reg [3];
    logic signed [VW-1:0] front_next [3];
    logic signed [VW-1:0] right_reg [2];
    logic signed [VW-1:0] right_next [2];
    logic signed [VW-1:0] up_reg [3];
    logic signed [VW-1:0] up_next [3];

    // Working registers
    logic [3:0]         state_reg, state_next;
    logic [3:0]         idx_reg, idx_next;
    logic [1:0]         mode_reg, mode_next;
    logic [2:0]         dir_reg, dir_next;
    logic [15:0]        ts_reg, ts_next;
    logic signed [15:0] mdx_reg, mdx_next;
    logic signed [15:0] mdy_reg, mdy_next;
    logic [39:0]        vel_reg, vel_next;
    logic [34:0]        wrap_reg, wrap_next;
    logic signed [31:0] cy_reg, cy_next, sy_reg, sy_next;
    logic signed [31:0] cp_reg, cp_next, sp_reg, sp_next;
    logic               mul_go_reg, mul_go_next;
    logic               cord_go_reg, cord_go_next;
    logic               out_valid_reg, out_valid_next;
    efcu_pkg::efcu_out_t out_reg, out_next;

    // Shared units
    logic signed [AW-1:0]  mul_a;
    logic signed [BW-1:0]  mul_b;
    logic signed [PRW-1:0] mul_p;
    logic                  mul_done;
    logic signed [24:0]    cord_ang;
    logic                  cord_done;
    logic signed [31:0]    cord_cos, cord_sin;

    logic                  in_xfer;
    logic signed [VW-1:0]  vsel;
    logic                  vneg;
    logic signed [63:0]    dstep;
    logic [34:0]           wsub, wafter;
    logic signed [33:0]    m30;

    assign in_xfer = in_ch.valid && in_ch.ready;

    efcu_smul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_go_reg),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    efcu_cordic #(.STEPS(TRIG_STEPS)) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cord_go_reg),
        .angle   (cord_ang),
        .done    (cord_done),
        .cos_out (cord_cos),
        .sin_out (cord_sin)
    );

    assign cord_ang = (state_reg == S_CORDY) ? yaw_reg : 25'(pitch_reg);

    // Pick the move axis component
    always_comb
    begin
        vsel = '0;
        if (dir_reg inside {efcu_pkg::DIR_FWD, efcu_pkg::DIR_BACK})
        begin
            case (idx_reg[1:0])
                2'd0:    vsel = front_reg[0];
                2'd1:    vsel = front_reg[1];
                2'd2:    vsel = front_reg[2];
                default: vsel = '0;
            endcase
        end
        else if (dir_reg inside {efcu_pkg::DIR_LEFT, efcu_pkg::DIR_RIGHT})
        begin
            case (idx_reg[1:0])
                2'd0:    vsel = right_reg[0];
                2'd2:    vsel = right_reg[1];
                default: vsel = '0;
            endcase
        end
        else
        begin
            vsel = (idx_reg[1:0] == 2'd1) ? VONE : '0;
        end
    end

    assign vneg = dir_reg inside {efcu_pkg::DIR_BACK, efcu_pkg::DIR_LEFT, efcu_pkg::DIR_DOWN};

    // Multiplier operands per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_VEL:
            begin
                mul_a = AW'(speed_reg);
                mul_b = BW'(ts_reg);
            end
            S_MOVE:
            begin
                mul_a = AW'(vel_reg);
                mul_b = BW'(vsel);
            end
            S_YMUL:
            begin
                mul_a = AW'(sens_reg);
                mul_b = BW'(mdx_reg);
            end
            S_PMUL:
            begin
                mul_a = AW'(sens_reg);
                mul_b = BW'(mdy_reg);
            end
            S_VMUL:
            begin
                mul_a = idx_reg[0] ? AW'(sy_reg) : AW'(cy_reg);
                mul_b = idx_reg[1] ? sp_reg : cp_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign dstep = 64'((mul_p + (PRW'(1) <<< (MSH - 1))) >>> MSH);
    assign wsub  = efcu_pkg::DEG_360_U << idx_reg;
    assign wafter = (wrap_reg >= wsub) ? (wrap_reg - wsub) : wrap_reg;
    assign m30   = mul30(mul_p);

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        mode_next    = mode_reg;
        dir_next     = dir_reg;
        ts_next      = ts_reg;
        mdx_next     = mdx_reg;
        mdy_next     = mdy_reg;
        vel_next     = vel_reg;
        wrap_next    = wrap_reg;
        cy_next      = cy_reg;
        sy_next      = sy_reg;
        cp_next      = cp_reg;
        sp_next      = sp_reg;
        yaw_next     = yaw_reg;
        pitch_next   = pitch_reg;
        pos_next     = pos_reg;
        front_next   = front_reg;
        right_next   = right_reg;
        up_next      = up_reg;
        mul_go_next  = 1'b0;
        cord_go_next = 1'b0;
        out_next     = out_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    mode_next = in_ch.data.mode;
                    dir_next  = in_ch.data.direction;
                    ts_next   = in_ch.data.time_step;
                    mdx_next  = in_ch.data.mouse_dx;
                    mdy_next  = in_ch.data.mouse_dy;
                    case (in_ch.data.mode)
                        efcu_pkg::MODE_MOVE:
                        begin
                            if (in_ch.data.direction inside {[3'd6:3'd7]})
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next  = S_VEL;
                                mul_go_next = 1'b1;
                            end
                        end
                        efcu_pkg::MODE_ROTATE:
                        begin
                            state_next  = S_YMUL;
                            mul_go_next = 1'b1;
                        end
                        efcu_pkg::MODE_RESTART:
                        begin
                            pos_next[0] = sat_pos(64'($signed(sx_reg)));
                            pos_next[1] = sat_pos(64'($signed(sy0_reg)));
                            pos_next[2] = sat_pos(64'($signed(sz_reg)));
                            wrap_next   = 35'($signed(syaw_reg)) + efcu_pkg::YAW_OFFSET;
                            pitch_next  = clamp_pitch(34'($signed(spitch_reg)));
                            idx_next    = 4'd8;
                            state_next  = S_WRAP;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_VEL:
            begin
                if (mul_done)
                begin
                    vel_next    = mul_p[39:0];
                    idx_next    = '0;
                    state_next  = S_MOVE;
                    mul_go_next = 1'b1;
                end
            end
            S_MOVE:
            begin
                // Round, orient and add one axis with saturation
                if (mul_done)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        if (idx_reg[1:0] == 2'(k))
                        begin
                            pos_next[k] = sat_pos(64'(pos_reg[k]) + (vneg ? -dstep : dstep));
                        end
                    end
                    if (idx_reg == 4'd2)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next    = idx_reg + 1'b1;
                        mul_go_next = 1'b1;
                    end
                end
            end
            S_YMUL:
            begin
                if (mul_done)
                begin
                    wrap_next  = 35'(34'(yaw_reg) + 34'(mul_p)) + efcu_pkg::YAW_OFFSET;
                    idx_next   = 4'd8;
                    state_next = S_WRAP;
                end
            end
            S_WRAP:
            begin
                // Restoring reduction by 360 degrees, one multiple per cycle
                wrap_next = wafter;
                if (idx_reg == 4'd0)
                begin
                    yaw_next = 25'(wafter - efcu_pkg::DEG_180_U);
                    if (mode_reg == efcu_pkg::MODE_ROTATE)
                    begin
                        state_next  = S_PMUL;
                        mul_go_next = 1'b1;
                    end
                    else
                    begin
                        state_next   = S_CORDY;
                        cord_go_next = 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            S_PMUL:
            begin
                if (mul_done)
                begin
                    pitch_next   = clamp_pitch(34'(pitch_reg) + 34'(mul_p));
                    state_next   = S_CORDY;
                    cord_go_next = 1'b1;
                end
            end
            S_CORDY:
            begin
                if (cord_done)
                begin
                    cy_next      = cord_cos;
                    sy_next      = cord_sin;
                    state_next   = S_CORDP;
                    cord_go_next = 1'b1;
                end
            end
            S_CORDP:
            begin
                if (cord_done)
                begin
                    cp_next       = cord_cos;
                    sp_next       = cord_sin;
                    front_next[1] = to_vec(34'(cord_sin));
                    right_next[0] = to_vec(-34'(sy_reg));
                    right_next[1] = to_vec(34'(cy_reg));
                    up_next[1]    = to_vec(34'(cord_cos));
                    idx_next      = '0;
                    state_next    = S_VMUL;
                    mul_go_next   = 1'b1;
                end
            end
            S_VMUL:
            begin
                // Products: cy*cp, sy*cp, cy*sp, sy*sp
                if (mul_done)
                begin
                    case (idx_reg[1:0])
                        2'd0:    front_next[0] = to_vec(m30);
                        2'd1:    front_next[2] = to_vec(m30);
                        2'd2:    up_next[0]    = to_vec(-m30);
                        default: up_next[2]    = to_vec(-m30);
                    endcase
                    if (idx_reg == 4'd3)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next    = idx_reg + 1'b1;
                        mul_go_next = 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                // Hand the pose to the output register once it is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_next.pos_x   = 32'(pos_reg[0]);
                    out_next.pos_y   = 32'(pos_reg[1]);
                    out_next.pos_z   = 32'(pos_reg[2]);
                    out_next.front_x = 16'(front_reg[0]);
                    out_next.front_y = 16'(front_reg[1]);
                    out_next.front_z = 16'(front_reg[2]);
                    out_next.right_x = 16'(right_reg[0]);
                    out_next.right_z = 16'(right_reg[1]);
                    out_next.up_x    = 16'(up_reg[0]);
                    out_next.up_y    = 16'(up_reg[1]);
                    out_next.up_z    = 16'(up_reg[2]);
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            mul_go_reg    <= 1'b0;
            cord_go_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            yaw_reg       <= '0;
            pitch_reg     <= '0;
            for (int k = 0; k < 3; k++)
            begin
                pos_reg[k] <= '0;
            end
            front_reg[0] <= VONE;
            front_reg[1] <= '0;
            front_reg[2] <= '0;
            right_reg[0] <= '0;
            right_reg[1] <= VONE;
            up_reg[0]    <= '0;
            up_reg[1]    <= VONE;
            up_reg[2]    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            mul_go_reg    <= mul_go_next;
            cord_go_reg   <= cord_go_next;
            out_valid_reg <= out_valid_next;
            yaw_reg       <= yaw_next;
            pitch_reg     <= pitch_next;
            pos_reg       <= pos_next;
            front_reg     <= front_next;
            right_reg     <= right_next;
            up_reg        <= up_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        dir_reg  <= dir_next;
        ts_reg   <= ts_next;
        mdx_reg  <= mdx_next;
        mdy_reg  <= mdy_next;
        vel_reg  <= vel_next;
        wrap_reg <= wrap_next;
        cy_reg   <= cy_next;
        sy_reg   <= sy_next;
        cp_reg   <= cp_next;
        sp_reg   <= sp_next;
        out_reg  <= out_next;
    end

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg  <= efcu_pkg::MOVE_SPEED_RST;
            sens_reg   <= efcu_pkg::LOOK_SENS_RST;
            sx_reg     <= '0;
            sy0_reg    <= '0;
            sz_reg     <= '0;
            syaw_reg   <= '0;
            spitch_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                efcu_pkg::REG_MOVE_SPEED:  speed_reg  <= cfg_data[23:0];
                efcu_pkg::REG_LOOK_SENS:   sens_reg   <= cfg_data[15:0];
                efcu_pkg::REG_START_X:     sx_reg     <= cfg_data;
                efcu_pkg::REG_START_Y:     sy0_reg    <= cfg_data;
                efcu_pkg::REG_START_Z:     sz_reg     <= cfg_data;
                efcu_pkg::REG_START_YAW:   syaw_reg   <= cfg_data[24:0];
                efcu_pkg::REG_START_PITCH: spitch_reg <= cfg_data[23:0];
                default:                   speed_reg  <= speed_reg;
            endcase
        end
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    // Yaw stays wrapped between items
    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |->
            (26'(yaw_reg) >= -efcu_pkg::DEG_180 && 26'(yaw_reg) < efcu_pkg::DEG_180))
        else $error("yaw out of range");

    // Pitch never leaves the clamp
    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        (34'(pitch_reg) <= efcu_pkg::PITCH_LIM && 34'(pitch_reg) >= -efcu_pkg::PITCH_LIM))
        else $error("pitch out of range");

    // A multiply starts only in a step that consumes it
    a_mul_go: assert property (@(posedge clk) disable iff (!rst_n)
        mul_go_reg |-> (state_reg == S_VEL || state_reg == S_MOVE || state_reg == S_YMUL
                        || state_reg == S_PMUL || state_reg == S_VMUL))
        else $error("multiply started in wrong step");

    // One item at a time: a transfer closes the input
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ch.ready)
        else $error("input accepted while busy");

endmodule
